@@ src/pscs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscs_pkg
// Shared types and character constants for the Python string/comment scanner.
// ----------------------------------------------------------------------------
package pscs_pkg;

   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_BSL  = 8'h5C;
   localparam logic [7:0] CH_SQ   = 8'h27;
   localparam logic [7:0] CH_DQ   = 8'h22;

   localparam logic [1:0] CLASS_STATEMENT = 2'd0;
   localparam logic [1:0] CLASS_STRING    = 2'd1;
   localparam logic [1:0] CLASS_MULTILINE = 2'd2;
   localparam logic [1:0] CLASS_COMMENT   = 2'd3;

   typedef enum logic [4:0] {
      S_CODE     = 5'd0,
      S_SQ       = 5'd1,
      S_SQ_ESC   = 5'd2,
      S_DQ       = 5'd3,
      S_DQ_ESC   = 5'd4,
      S_SQ_OPEN  = 5'd5,
      S_DQ_OPEN  = 5'd6,
      S_SQ_EMPTY = 5'd7,
      S_DQ_EMPTY = 5'd8,
      S_T_SQ     = 5'd9,
      S_T_DQ     = 5'd10,
      S_T_SQ_ESC = 5'd11,
      S_T_DQ_ESC = 5'd12,
      S_T_SQ_ONE = 5'd13,
      S_T_SQ_TWO = 5'd14,
      S_T_DQ_ONE = 5'd15,
      S_T_DQ_TWO = 5'd16,
      S_COMMENT  = 5'd17
   } scan_state_type;

   typedef struct packed {
      logic [7:0] multiline_quote;
      logic [1:0] context_class;
   } scan_result_type;

endpackage

@@ src/pscs_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscs_step
// Next-state and result decode of the lexical context machine for one byte.
// ----------------------------------------------------------------------------
module pscs_step
   import pscs_pkg::*;
(
   input  scan_state_type  state_cur,
   input  logic [7:0]      char_in,
   output scan_state_type  state_nxt,
   output scan_result_type result
);

   logic is_bsl;
   logic is_sq;
   logic is_dq;

   assign is_bsl = (char_in == CH_BSL);
   assign is_sq  = (char_in == CH_SQ);
   assign is_dq  = (char_in == CH_DQ);

   always_comb begin
      unique case (state_cur)
         S_COMMENT: begin
            state_nxt = (char_in == CH_CR || char_in == CH_LF) ? S_CODE : S_COMMENT;
         end
         S_SQ_OPEN: begin
            if (is_bsl)     state_nxt = S_SQ_ESC;
            else if (is_sq) state_nxt = S_SQ_EMPTY;
            else            state_nxt = S_SQ;
         end
         S_SQ_ESC: state_nxt = S_SQ;
         S_SQ: begin
            if (is_bsl)     state_nxt = S_SQ_ESC;
            else if (is_sq) state_nxt = S_CODE;
            else            state_nxt = S_SQ;
         end
         S_SQ_EMPTY: state_nxt = is_sq ? S_T_SQ : S_CODE;
         S_T_SQ: begin
            if (is_bsl)     state_nxt = S_T_SQ_ESC;
            else if (is_sq) state_nxt = S_T_SQ_ONE;
            else            state_nxt = S_T_SQ;
         end
         S_T_SQ_ESC: state_nxt = S_T_SQ;
         S_T_SQ_ONE: begin
            if (is_bsl)     state_nxt = S_T_SQ_ESC;
            else if (is_sq) state_nxt = S_T_SQ_TWO;
            else            state_nxt = S_T_SQ;
         end
         S_T_SQ_TWO: begin
            if (is_bsl)     state_nxt = S_T_SQ_ESC;
            else if (is_sq) state_nxt = S_CODE;
            else            state_nxt = S_T_SQ;
         end
         S_DQ_OPEN: begin
            if (is_bsl)     state_nxt = S_DQ_ESC;
            else if (is_dq) state_nxt = S_DQ_EMPTY;
            else            state_nxt = S_DQ;
         end
         S_DQ_ESC: state_nxt = S_DQ;
         S_DQ: begin
            if (is_bsl)     state_nxt = S_DQ_ESC;
            else if (is_dq) state_nxt = S_CODE;
            else            state_nxt = S_DQ;
         end
         S_DQ_EMPTY: state_nxt = is_dq ? S_T_DQ : S_CODE;
         S_T_DQ: begin
            if (is_bsl)     state_nxt = S_T_DQ_ESC;
            else if (is_dq) state_nxt = S_T_DQ_ONE;
            else            state_nxt = S_T_DQ;
         end
         S_T_DQ_ESC: state_nxt = S_T_DQ;
         S_T_DQ_ONE: begin
            if (is_bsl)     state_nxt = S_T_DQ_ESC;
            else if (is_dq) state_nxt = S_T_DQ_TWO;
            else            state_nxt = S_T_DQ;
         end
         S_T_DQ_TWO: begin
            if (is_bsl)     state_nxt = S_T_DQ_ESC;
            else if (is_dq) state_nxt = S_CODE;
            else            state_nxt = S_T_DQ;
         end
         default: begin
            // statement, and any unused code
            if (is_sq)                  state_nxt = S_SQ_OPEN;
            else if (is_dq)             state_nxt = S_DQ_OPEN;
            else if (char_in == CH_HASH) state_nxt = S_COMMENT;
            else                        state_nxt = S_CODE;
         end
      endcase
   end

   always_comb begin
      unique case (state_nxt)
         S_SQ, S_SQ_ESC, S_DQ, S_DQ_ESC, S_SQ_OPEN, S_DQ_OPEN: begin
            result.context_class   = CLASS_STRING;
            result.multiline_quote = 8'd0;
         end
         S_T_SQ, S_T_SQ_ESC, S_T_SQ_ONE, S_T_SQ_TWO: begin
            result.context_class   = CLASS_MULTILINE;
            result.multiline_quote = CH_SQ;
         end
         S_T_DQ, S_T_DQ_ESC, S_T_DQ_ONE, S_T_DQ_TWO: begin
            result.context_class   = CLASS_MULTILINE;
            result.multiline_quote = CH_DQ;
         end
         S_COMMENT: begin
            result.context_class   = CLASS_COMMENT;
            result.multiline_quote = 8'd0;
         end
         default: begin
            result.context_class   = CLASS_STATEMENT;
            result.multiline_quote = 8'd0;
         end
      endcase
   end

endmodule

@@ src/python_string_comment_scanner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// python_string_comment_scanner
// Tracks Python lexical context (code, strings, triple-quoted strings,
// comments) one source byte per beat and reports the context after each byte.
// ----------------------------------------------------------------------------
// An accepted req beat yields its rsp beat in the following cycle.
// Throughput: 1 byte per cycle while req_tready is high; state_ff loads on accept.
// A single output register decouples the sides; req_tready drops only while a
// result is held and rsp_tready is low.
// Reset: synchronous; clears the output valid and returns the scanner to the
// statement context.
module python_string_comment_scanner
   import pscs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [1:0] context_class, [9:2] multiline_quote, [15:10] 0
);

   scan_state_type  state_ff;
   scan_state_type  state_in;
   scan_result_type result_ff;
   scan_result_type result_in;
   logic            rsp_valid_ff;
   logic            req_accept;

   pscs_step u_step (
      .state_cur (state_ff),
      .char_in   (req_tdata),
      .state_nxt (state_in),
      .result    (result_in)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CODE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, result_ff.multiline_quote, result_ff.context_class};

   a_quote_only_multiline: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((result_ff.context_class == CLASS_MULTILINE)
                        == (result_ff.multiline_quote != 8'd0)))
      else $error("multiline_quote disagrees with context_class");

   a_quote_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff.context_class == CLASS_MULTILINE) |->
      (result_ff.multiline_quote == CH_SQ || result_ff.multiline_quote == CH_DQ))
      else $error("multiline_quote is not a quote character");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted byte produced no result");

   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> $stable(state_ff))
      else $error("scanner state moved while output stalled");

endmodule
